// ===== sv/websocket_client_frame_encoder_macros.svh =====
// ---------------------------------------------------------------------------
// websocket client frame encoder assertion macros
// shared concurrent assertion helpers, empty when SYNTHESIS is defined
// ---------------------------------------------------------------------------
`ifndef WEBSOCKET_CLIENT_FRAME_ENCODER_MACROS_SVH
`define WEBSOCKET_CLIENT_FRAME_ENCODER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define WSCFE_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wscfe assertion failed");
// next-cycle implication
`define WSCFE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wscfe assertion failed");
`else
`define WSCFE_ASSERT_IMP(label, clk, rst, ante, cons)
`define WSCFE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== sv/wscfe_pkg.sv =====
// ---------------------------------------------------------------------------
// wscfe_pkg
// types and constants of the websocket client frame encoder
// ---------------------------------------------------------------------------
`default_nettype none

package wscfe_pkg;

  localparam int MaxRun = 8;
  localparam int CntW   = $clog2(MaxRun + 1);

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_CLOSE = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_TOO_LARGE = 2'd1,
    STATUS_UNEXPECTED = 2'd2
  } status_t;

  localparam logic [7:0]  HDR_TEXT    = 8'h81;
  localparam logic [7:0]  HDR_CLOSE   = 8'h88;
  localparam logic [7:0]  LEN_MASKED  = 8'h80;
  localparam logic [7:0]  LEN_EXT16   = 8'hFE;
  localparam logic [11:0] SHORT_LIMIT = 12'd126;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       frame_end;
    status_t    status;
  } result_t;

  // one input's worth of results, entry 0 goes out first
  typedef struct packed {
    result_t [MaxRun-1:0] entries;
    logic [CntW-1:0]      count;
  } run_t;

  function automatic logic [7:0] mask_byte(input logic [31:0] key, input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = key[31:24];
      2'd1:    b = key[23:16];
      2'd2:    b = key[15:8];
      default: b = key[7:0];
    endcase
    return b;
  endfunction

  function automatic result_t frame_byte(input logic [7:0] b, input logic last);
    result_t r;
    r.out_byte   = b;
    r.byte_valid = 1'b1;
    r.frame_end  = last;
    r.status     = STATUS_OK;
    return r;
  endfunction

  function automatic result_t status_only(input status_t s);
    result_t r;
    r.out_byte   = 8'd0;
    r.byte_valid = 1'b0;
    r.frame_end  = 1'b0;
    r.status     = s;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/wscfe_frame_ctrl.sv =====
// ---------------------------------------------------------------------------
// wscfe_frame_ctrl
// input register, frame state and decode of one command into a byte run
// ---------------------------------------------------------------------------
`default_nettype none
`include "websocket_client_frame_encoder_macros.svh"

module wscfe_frame_ctrl #(
  parameter int MAX_PAYLOAD = 4096
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [1:0]   command,
  input  wire logic [11:0]  payload_length,
  input  wire logic [31:0]  mask_key,
  input  wire logic [7:0]   data_byte,
  input  wire logic         emit_free,
  output logic              run_load,
  output wscfe_pkg::run_t   run
);
  import wscfe_pkg::*;

  logic        item_vld;
  cmd_t        item_cmd;
  logic [11:0] item_len;
  logic [31:0] item_key;
  logic [7:0]  item_data;

  logic [11:0] bytes_left, bytes_left_next;
  logic [1:0]  mask_index, mask_index_next;
  logic [31:0] held_mask, held_mask_next;
  logic        in_frame, in_frame_next;

  logic        last_byte;
  logic        empty_len;

  assign in_ready = !item_vld || emit_free;
  assign run_load = item_vld && emit_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_vld <= 1'b0;
    end else if (in_ready) begin
      item_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_cmd  <= cmd_t'(command);
      item_len  <= payload_length;
      item_key  <= mask_key;
      item_data <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left <= '0;
      mask_index <= '0;
      held_mask  <= '0;
      in_frame   <= 1'b0;
    end else if (run_load) begin
      bytes_left <= bytes_left_next;
      mask_index <= mask_index_next;
      held_mask  <= held_mask_next;
      in_frame   <= in_frame_next;
    end
  end

  assign last_byte = (bytes_left <= 12'd1);
  assign empty_len = (item_len == 12'd0);

  always_comb begin
    run             = '0;
    bytes_left_next = bytes_left;
    mask_index_next = mask_index;
    held_mask_next  = held_mask;
    in_frame_next   = in_frame;
    case (item_cmd)
      CMD_START: begin
        if (int'(item_len) >= MAX_PAYLOAD) begin
          run.entries[0] = status_only(STATUS_TOO_LARGE);
          run.count      = CntW'(1);
        end else begin
          run.entries[0] = frame_byte(HDR_TEXT, 1'b0);
          if (item_len < SHORT_LIMIT) begin
            run.entries[1] = frame_byte(LEN_MASKED | {1'b0, item_len[6:0]}, 1'b0);
            for (int i = 0; i < 4; i++) begin
              run.entries[2+i] = frame_byte(mask_byte(item_key, 2'(i)),
                                            empty_len && (i == 3));
            end
            run.count = CntW'(6);
          end else begin
            run.entries[1] = frame_byte(LEN_EXT16, 1'b0);
            run.entries[2] = frame_byte({4'd0, item_len[11:8]}, 1'b0);
            run.entries[3] = frame_byte(item_len[7:0], 1'b0);
            for (int i = 0; i < 4; i++) begin
              run.entries[4+i] = frame_byte(mask_byte(item_key, 2'(i)), 1'b0);
            end
            run.count = CntW'(8);
          end
          held_mask_next  = item_key;
          mask_index_next = 2'd0;
          bytes_left_next = item_len;
          in_frame_next   = !empty_len;
        end
      end
      CMD_BYTE: begin
        run.count = CntW'(1);
        if (!in_frame) begin
          run.entries[0] = status_only(STATUS_UNEXPECTED);
        end else begin
          run.entries[0] = frame_byte(item_data ^ mask_byte(held_mask, mask_index),
                                      last_byte);
          mask_index_next = mask_index + 2'd1;
          if (last_byte) begin
            bytes_left_next = '0;
            in_frame_next   = 1'b0;
          end else begin
            bytes_left_next = bytes_left - 12'd1;
          end
        end
      end
      CMD_CLOSE: begin
        run.entries[0] = frame_byte(HDR_CLOSE, 1'b0);
        run.entries[1] = frame_byte(LEN_MASKED, 1'b0);
        for (int i = 0; i < 4; i++) begin
          run.entries[2+i] = frame_byte(mask_byte(item_key, 2'(i)), i == 3);
        end
        run.count       = CntW'(6);
        bytes_left_next = '0;
        mask_index_next = 2'd0;
        in_frame_next   = 1'b0;
      end
      default: begin
        run.count = '0;
      end
    endcase
  end

  // an idle encoder expects no payload, an open frame always expects some
  `WSCFE_ASSERT_IMP(a_idle_no_bytes, clk, rst, !in_frame, bytes_left == 12'd0)
  `WSCFE_ASSERT_IMP(a_open_has_bytes, clk, rst, in_frame, bytes_left != 12'd0)
  `WSCFE_ASSERT_IMP(a_load_has_item, clk, rst, run_load, run.count <= CntW'(MaxRun))

endmodule

`default_nettype wire

// ===== sv/wscfe_byte_emit.sv =====
// ---------------------------------------------------------------------------
// wscfe_byte_emit
// run buffer that shifts out one result per cycle into the output register while the output is not stalled
// ---------------------------------------------------------------------------
`default_nettype none
`include "websocket_client_frame_encoder_macros.svh"

module wscfe_byte_emit (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              run_load,
  input  wire wscfe_pkg::run_t   run,
  output logic                   emit_free,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output wscfe_pkg::result_t     out_res
);
  import wscfe_pkg::*;

  result_t [MaxRun-1:0] pending;
  logic [CntW-1:0]      pending_cnt;
  logic                 advance;

  assign advance   = (pending_cnt != '0) && (!out_valid || out_ready);
  assign emit_free = (pending_cnt == '0) || ((pending_cnt == CntW'(1)) && advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_cnt <= '0;
    end else if (run_load) begin
      pending_cnt <= run.count;
    end else if (advance) begin
      pending_cnt <= pending_cnt - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (run_load) begin
      pending <= run.entries;
    end else if (advance) begin
      for (int i = 0; i < MaxRun - 1; i++) begin
        pending[i] <= pending[i+1];
      end
      pending[MaxRun-1] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= pending[0];
    end
  end

  `WSCFE_ASSERT_IMP(a_cnt_range, clk, rst, 1'b1, pending_cnt <= CntW'(MaxRun))
  `WSCFE_ASSERT_NEXT(a_cnt_step, clk, rst, advance && !run_load,
                     pending_cnt == $past(pending_cnt) - CntW'(1))
  `WSCFE_ASSERT_IMP(a_end_is_byte, clk, rst, out_valid && out_res.frame_end,
                    out_res.byte_valid && (out_res.status == STATUS_OK))
  `WSCFE_ASSERT_IMP(a_status_only, clk, rst, out_valid && !out_res.byte_valid,
                    (out_res.out_byte == 8'd0) && (out_res.status != STATUS_OK))

endmodule

`default_nettype wire

// ===== sv/websocket_client_frame_encoder.sv =====
// ---------------------------------------------------------------------------
// websocket_client_frame_encoder
// masked client-to-server websocket frame byte stream builder
// ---------------------------------------------------------------------------
// a taken command passes the input register and the run buffer before its first result reaches the output register
// throughput: one result per cycle while the output is not stalled; payload commands go in at one per cycle
// a start command yields 6 or 8 header bytes, or one status result if too large,
// a close 6, each blocking input only until its last byte moves into the output register
// reset: synchronous, clears the frame state, the run buffer and both valids
`default_nettype none

module websocket_client_frame_encoder #(
  parameter int MAX_PAYLOAD = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  command,
  input  wire logic [11:0] payload_length,
  input  wire logic [31:0] mask_key,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic             byte_valid,
  output logic             frame_end,
  output logic [1:0]       status
);
  import wscfe_pkg::*;

  logic    emit_free;
  logic    run_load;
  run_t    run;
  result_t out_res;

  wscfe_frame_ctrl #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_frame_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .payload_length (payload_length),
    .mask_key       (mask_key),
    .data_byte      (data_byte),
    .emit_free      (emit_free),
    .run_load       (run_load),
    .run            (run)
  );

  wscfe_byte_emit u_byte_emit (
    .clk       (clk),
    .rst       (rst),
    .run_load  (run_load),
    .run       (run),
    .emit_free (emit_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_byte   = out_res.out_byte;
  assign byte_valid = out_res.byte_valid;
  assign frame_end  = out_res.frame_end;
  assign status     = out_res.status;

endmodule

`default_nettype wire
